// File: src/lts_pkg.sv
package lts_pkg;

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'd0;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_SP    = 8'd32;
  localparam logic [7:0] CH_BANG  = 8'd33;
  localparam logic [7:0] CH_DQ    = 8'd34;
  localparam logic [7:0] CH_PCT   = 8'd37;
  localparam logic [7:0] CH_SQ    = 8'd39;
  localparam logic [7:0] CH_STAR  = 8'd42;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_DOT   = 8'd46;
  localparam logic [7:0] CH_SLASH = 8'd47;
  localparam logic [7:0] CH_LT    = 8'd60;
  localparam logic [7:0] CH_EQ    = 8'd61;
  localparam logic [7:0] CH_GT    = 8'd62;
  localparam logic [7:0] CH_USCR  = 8'd95;

  // Result queue geometry (power of two)
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_AW    = $clog2(Q_DEPTH);

  typedef struct packed {
    logic [7:0] token_char;
    logic       token_start;
    logic       run_last;
  } res_t;

  // Results of one decoded byte: cnt of 0, 1 or 2 valid entries in res
  typedef struct packed {
    logic [1:0]      cnt;
    res_t [1:0]      res;
  } dec_t;

  typedef struct packed {
    logic [Q_AW:0] level;
    logic          space;
  } q_stat_t;

endpackage

// File: src/lts_if.sv
interface lts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;

  modport source (output valid, output char_in, input ready);
  modport sink (input valid, input char_in, output ready);
endinterface

interface lts_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] token_char;
  logic       token_start;
  logic       run_last;

  modport source (output valid, output token_char, output token_start, output run_last,
                  input ready);
  modport sink (input valid, input token_char, input token_start, input run_last,
                output ready);
endinterface

// File: src/lts_decode.sv
module lts_decode (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire_i,
  input  logic [7:0]       char_i,
  output lts_pkg::dec_t    dec_o
);

  typedef struct packed {
    logic       emit;
    logic       start;
    logic       hv;
    logic [7:0] hc;
    logic       iw;
    logic       iq;
  } fresh_t;

  logic [7:0] held_char_r, held_char_nxt;
  logic       held_valid_r, held_valid_nxt;
  logic       in_word_r, in_word_nxt;
  logic       in_quote_r, in_quote_nxt;

  fresh_t     f_open;
  fresh_t     f_after;

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[8'd48:8'd57]};
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_digit(c) || (c inside {[8'd65:8'd90]}) || (c inside {[8'd97:8'd122]});
  endfunction

  function automatic logic is_rep_op(input logic [7:0] c);
    return c inside {lts_pkg::CH_PLUS, lts_pkg::CH_MINUS, lts_pkg::CH_GT,
                     lts_pkg::CH_LT, lts_pkg::CH_STAR};
  endfunction

  function automatic logic is_eq_op(input logic [7:0] c);
    return c inside {lts_pkg::CH_SLASH, lts_pkg::CH_PCT, lts_pkg::CH_BANG, lts_pkg::CH_EQ};
  endfunction

  function automatic logic pairs_with(input logic [7:0] h, input logic [7:0] c);
    logic p;
    p = 1'b0;
    if (is_rep_op(h)) begin
      p = (c == h) || (c == lts_pkg::CH_EQ);
    end else if (is_eq_op(h)) begin
      p = (c == lts_pkg::CH_EQ);
    end else if (h == lts_pkg::CH_USCR) begin
      p = (c == lts_pkg::CH_SLASH);
    end
    return p;
  endfunction

  // Handle a byte with nothing held and no string open
  function automatic fresh_t do_fresh(input logic [7:0] c, input logic iw,
                                      input logic [7:0] hc);
    fresh_t f;
    f.emit  = 1'b0;
    f.start = 1'b1;
    f.hv    = 1'b0;
    f.hc    = hc;
    f.iw    = iw;
    f.iq    = 1'b0;
    if (c == lts_pkg::CH_NUL) begin
      f.hc = 8'd0;
      f.iw = 1'b0;
    end else if (c == lts_pkg::CH_LF || c == lts_pkg::CH_SP) begin
      f.iw = 1'b0;
    end else if (is_alnum(c)) begin
      f.emit  = 1'b1;
      f.start = !iw;
      f.iw    = 1'b1;
    end else if (c == lts_pkg::CH_DOT || is_rep_op(c) || is_eq_op(c) ||
                 c == lts_pkg::CH_USCR) begin
      f.hv = 1'b1;
      f.hc = c;
    end else if (c == lts_pkg::CH_DQ || c == lts_pkg::CH_SQ) begin
      f.emit  = 1'b1;
      f.start = !iw;
      f.iq    = 1'b1;
      f.iw    = 1'b1;
    end else begin
      f.emit = 1'b1;
      f.iw   = 1'b0;
    end
    return f;
  endfunction

  always_comb begin
    f_open  = do_fresh(char_i, in_word_r, held_char_r);
    f_after = do_fresh(char_i, 1'b0, 8'd0);

    held_char_nxt  = held_char_r;
    held_valid_nxt = held_valid_r;
    in_word_nxt    = in_word_r;
    in_quote_nxt   = in_quote_r;

    dec_o.cnt    = 2'd0;
    dec_o.res[0] = '{token_char: char_i, token_start: 1'b0, run_last: 1'b0};
    dec_o.res[1] = '{token_char: char_i, token_start: 1'b0, run_last: 1'b1};

    if (in_quote_r) begin
      if (char_i == lts_pkg::CH_NUL) begin
        held_char_nxt  = 8'd0;
        held_valid_nxt = 1'b0;
        in_word_nxt    = 1'b0;
        in_quote_nxt   = 1'b0;
      end else begin
        dec_o.cnt = 2'd1;
        if (char_i == lts_pkg::CH_DQ || char_i == lts_pkg::CH_SQ) begin
          in_quote_nxt = 1'b0;
          in_word_nxt  = 1'b0;
        end
      end
    end else if (held_valid_r) begin
      held_valid_nxt = 1'b0;
      held_char_nxt  = 8'd0;
      dec_o.res[0].token_char  = held_char_r;
      dec_o.res[0].token_start = 1'b1;
      if (held_char_r == lts_pkg::CH_DOT && is_digit(char_i)) begin
        // dot joins the number
        dec_o.cnt                = 2'd2;
        dec_o.res[0].token_start = !in_word_r;
        in_word_nxt              = 1'b1;
      end else if (held_char_r != lts_pkg::CH_DOT && pairs_with(held_char_r, char_i)) begin
        dec_o.cnt   = 2'd2;
        in_word_nxt = 1'b0;
      end else begin
        // flush the held byte, then handle this one afresh
        dec_o.cnt                = f_after.emit ? 2'd2 : 2'd1;
        dec_o.res[1].token_start = f_after.start;
        held_valid_nxt           = f_after.hv;
        held_char_nxt            = f_after.hc;
        in_word_nxt              = f_after.iw;
        in_quote_nxt             = f_after.iq;
      end
    end else begin
      dec_o.cnt                = {1'b0, f_open.emit};
      dec_o.res[0].token_start = f_open.start;
      held_valid_nxt           = f_open.hv;
      held_char_nxt            = f_open.hc;
      in_word_nxt              = f_open.iw;
      in_quote_nxt             = f_open.iq;
    end

    dec_o.res[0].run_last = (dec_o.cnt == 2'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_char_r  <= 8'd0;
      held_valid_r <= 1'b0;
      in_word_r    <= 1'b0;
      in_quote_r   <= 1'b0;
    end else if (fire_i) begin
      held_char_r  <= held_char_nxt;
      held_valid_r <= held_valid_nxt;
      in_word_r    <= in_word_nxt;
      in_quote_r   <= in_quote_nxt;
    end
  end

endmodule

// File: src/lts_out_q.sv
module lts_out_q (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_i,
  input  lts_pkg::dec_t      dec_i,
  output lts_pkg::q_stat_t   stat_o,
  lts_out_if.source          out_ch
);

  localparam int unsigned DEPTH = lts_pkg::Q_DEPTH;
  localparam int unsigned AW    = lts_pkg::Q_AW;

  lts_pkg::res_t  mem [DEPTH];
  logic [AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]    level_r, level_nxt;
  logic [1:0]     push_n;
  logic           pop;

  assign pop    = out_ch.valid && out_ch.ready;
  assign push_n = push_i ? dec_i.cnt : 2'd0;

  assign wr_ptr_nxt = wr_ptr_r + AW'(push_n);
  assign rd_ptr_nxt = rd_ptr_r + AW'(pop);
  assign level_nxt  = level_r + (AW+1)'(push_n) - (AW+1)'(pop);

  assign out_ch.valid       = (level_r != '0);
  assign out_ch.token_char  = mem[rd_ptr_r].token_char;
  assign out_ch.token_start = mem[rd_ptr_r].token_start;
  assign out_ch.run_last    = mem[rd_ptr_r].run_last;

  assign stat_o.level = level_r;
  assign stat_o.space = (level_r <= (AW+1)'(DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wr_ptr_r] <= dec_i.res[0];
    end
    if (push_n == 2'd2) begin
      mem[wr_ptr_r + AW'(1)] <= dec_i.res[1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

endmodule

// File: src/lexer_token_splitter.sv
// Token splitter: source bytes in, token bytes out.
// in_ch carries one source byte per beat (char_in, 0 ends the text).
// out_ch carries one token byte per beat with token_start marking the first
// byte of a token and run_last marking the last beat caused by an input byte.
// One input byte yields zero, one or two output beats: a dot or an operator
// is held until the next byte decides whether it pairs with it.
// Path: a byte accepted from in_ch sits in the input register until the
// result queue has two free entries, is then decoded into the queue, and
// its first result is valid at out_ch once that queue write is registered.
// Throughput: one input byte per cycle unless stalled; output drains one beat
// per cycle while out_ch.ready is high, so bytes that yield two results slow
// the input; the four-entry queue decodes a byte only with two free entries.
// Stall: when out_ch.ready is low the queue fills, the decoder holds, and
// in_ch.ready drops once the input register is also full. No beat is lost.
// Reset (rst_n low, synchronous): the queue empties, nothing is held, and
// the word and string flags clear.
module lexer_token_splitter (
  input  logic      clk,
  input  logic      rst_n,
  lts_in_if.sink    in_ch,
  lts_out_if.source out_ch
);

  logic             in_valid_r;
  logic [7:0]       in_char_r;
  logic             dec_fire;
  lts_pkg::dec_t    dec;
  lts_pkg::q_stat_t q_stat;

  assign dec_fire    = in_valid_r && q_stat.space;
  assign in_ch.ready = !in_valid_r || dec_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      in_valid_r <= 1'b1;
    end else if (dec_fire) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_char_r <= in_ch.char_in;
    end
  end

  lts_decode u_decode (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire_i (dec_fire),
    .char_i (in_char_r),
    .dec_o  (dec)
  );

  lts_out_q u_out_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_i (dec_fire),
    .dec_i  (dec),
    .stat_o (q_stat),
    .out_ch (out_ch)
  );

`ifndef SYNTHESIS
  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.level <= (lts_pkg::Q_AW + 1)'(lts_pkg::Q_DEPTH))
    else $error("result queue overflow");

  a_no_rise_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !dec_fire |=> q_stat.level <= $past(q_stat.level))
    else $error("result queue grew without a decode");

  a_stall_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !q_stat.space) |-> !in_ch.ready)
    else $error("input taken while input register is stuck");
`endif

endmodule
